>>> sv/ecal_pkg.sv
// Shared types and constants for the epoch seconds to calendar converter.
package ecal_pkg;

    localparam int CNT_W = 7;
    localparam int DIVR_W = 18;

    localparam logic [63:0] EPOCH_FROM_YEAR0 = 64'd62167219200;

    localparam logic [DIVR_W-1:0] DIV_MIN     = 18'd60;
    localparam logic [DIVR_W-1:0] DIV_DAY     = 18'd24;
    localparam logic [DIVR_W-1:0] DIV_ERA     = 18'd146097;
    localparam logic [DIVR_W-1:0] DIV_4Y      = 18'd1460;
    localparam logic [DIVR_W-1:0] DIV_100Y    = 18'd36524;
    localparam logic [DIVR_W-1:0] DIV_400Y    = 18'd146096;
    localparam logic [DIVR_W-1:0] DIV_YEAR    = 18'd365;
    localparam logic [DIVR_W-1:0] DIV_CENTURY = 18'd100;
    localparam logic [DIVR_W-1:0] DIV_MONTH   = 18'd153;
    localparam logic [DIVR_W-1:0] DIV_FIVE    = 18'd5;

    localparam int MAR1_DAYS = 60;

    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  nbits;
        logic [DIVR_W-1:0] divisor;
    } t_div_ctl;

    typedef struct packed {
        logic              done;
        logic [DIVR_W-1:0] rem;
    } t_div_stat;

endpackage

>>> sv/ecal_div.sv
// Bit-serial restoring divider: one dividend bit per cycle, MSB-aligned dividend.
module ecal_div #(
    parameter int TW = 41
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ecal_pkg::t_div_ctl    i_ctl,
    input  logic [TW-1:0]         i_dividend,
    output ecal_pkg::t_div_stat   o_stat,
    output logic [TW-1:0]         o_quotient
);

    logic [TW-1:0]                    r_num;
    logic [TW-1:0]                    r_quo;
    logic [ecal_pkg::DIVR_W-1:0]      r_rem;
    logic [ecal_pkg::DIVR_W-1:0]      r_div;
    logic [ecal_pkg::CNT_W-1:0]       r_cnt;
    logic                             r_done;

    logic [ecal_pkg::DIVR_W:0]        trial;
    logic [ecal_pkg::DIVR_W:0]        diff;
    logic                             ge;
    logic [ecal_pkg::DIVR_W-1:0]      n_rem;

    assign trial = {r_rem, r_num[TW-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};
    assign n_rem = ge ? diff[ecal_pkg::DIVR_W-1:0] : trial[ecal_pkg::DIVR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_num <= i_dividend;
                r_rem <= '0;
                r_quo <= '0;
                r_div <= i_ctl.divisor;
                r_cnt <= i_ctl.nbits;
            end else if (r_cnt != '0) begin
                // shift in the next dividend bit, one quotient bit out
                r_num <= {r_num[TW-2:0], 1'b0};
                r_rem <= n_rem;
                r_quo <= {r_quo[TW-2:0], ge};
                r_cnt <= r_cnt - ecal_pkg::CNT_W'(1);
                if (r_cnt == ecal_pkg::CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem;
    assign o_quotient  = r_quo;

endmodule

>>> sv/epoch_seconds_to_calendar_unit.sv
// The result is computed by a sequence of divisions on the shared bit-serial divider, TW = max(SECONDS_WIDTH,36)+1
// bits wide, one bit per cycle.
// One request is processed at a time; the next request is taken while the
// finished result waits in the output register.
// Reset (synchronous, active low) clears the sequencer, the output valid and sets the zone
// offset to zero.
module epoch_seconds_to_calendar_unit #(
    parameter int SECONDS_WIDTH = 40
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [17:0]                            i_cfg_data,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // seconds_count
    input  logic [((SECONDS_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // year[15:0], month[19:16], day_of_month[24:20], hour[29:25], minute[35:30],
    // second[41:36], zero pad
    output logic [47:0]                            o_m_axis_tdata
);

    localparam int TW = ((SECONDS_WIDTH > 36) ? SECONDS_WIDTH : 36) + 1;
    localparam int ZW = TW - 16;
    localparam logic [63:0] EPOCH = ecal_pkg::EPOCH_FROM_YEAR0;
    localparam logic [ecal_pkg::CNT_W-1:0] NB_SEC  = ecal_pkg::CNT_W'(TW);
    localparam logic [ecal_pkg::CNT_W-1:0] NB_MIN  = ecal_pkg::CNT_W'(TW - 5);
    localparam logic [ecal_pkg::CNT_W-1:0] NB_HOUR = ecal_pkg::CNT_W'(TW - 11);
    localparam logic [ecal_pkg::CNT_W-1:0] NB_ERA  = ecal_pkg::CNT_W'(TW - 16);
    localparam logic [ecal_pkg::CNT_W-1:0] NB_DOE  = ecal_pkg::CNT_W'(18);
    localparam logic [ecal_pkg::CNT_W-1:0] NB_YOE  = ecal_pkg::CNT_W'(9);
    localparam logic [ecal_pkg::CNT_W-1:0] NB_DOY  = ecal_pkg::CNT_W'(11);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_SEC, S_MIN, S_HOUR, S_ERA, S_Q1, S_Q2, S_Q3,
        S_YOE, S_C100, S_MP, S_DOM, S_OUT
    } t_state;

    t_state               r_state;
    logic [17:0]          r_zone;
    logic [TW-1:0]        r_t;
    logic [5:0]           r_sec;
    logic [5:0]           r_min;
    logic [4:0]           r_hour;
    logic [11:0]          r_era;
    logic [17:0]          r_doe;
    logic [17:0]          r_acc;
    logic [8:0]           r_yoe;
    logic [8:0]           r_doy;
    logic [3:0]           r_mp;
    logic                 r_out_valid;
    logic [15:0]          r_o_year;
    logic [3:0]           r_o_mon;
    logic [4:0]           r_o_dom;
    logic [4:0]           r_o_hour;
    logic [5:0]           r_o_min;
    logic [5:0]           r_o_sec;

    ecal_pkg::t_div_ctl   div_ctl;
    ecal_pkg::t_div_stat  div_stat;
    logic [TW-1:0]        div_dividend;
    logic [TW-1:0]        q;

    logic                 in_acc;
    logic                 out_free;
    logic [TW-1:0]        t_sum;
    logic [ZW-1:0]        z;
    logic [17:0]          acc_nx;
    logic [17:0]          yoe_days;
    logic [17:0]          doy_w;
    logic [8:0]           dom_w;
    logic [3:0]           mon_w;
    logic [15:0]          year_w;

    ecal_div #(
        .TW (TW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .o_stat     (div_stat),
        .o_quotient (q)
    );

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    assign t_sum = {{(TW-SECONDS_WIDTH){1'b0}}, i_s_axis_tdata[SECONDS_WIDTH-1:0]}
                 + EPOCH[TW-1:0]
                 + {{(TW-18){r_zone[17]}}, r_zone};

    // day count from 0000-03-01 so that the leap day closes each year
    assign z        = q[ZW-1:0] - ZW'(ecal_pkg::MAR1_DAYS);
    assign acc_nx   = r_acc - q[17:0];
    assign yoe_days = 18'(r_yoe) * 18'd365 + 18'(r_yoe[8:2]) - 18'(q[8:0]);
    assign doy_w    = r_doe - yoe_days;
    assign dom_w    = r_doy - q[8:0] + 9'd1;
    assign mon_w    = (r_mp < 4'd10) ? r_mp + 4'd3 : r_mp - 4'd9;
    assign year_w   = 16'(r_yoe) + {r_era[7:0], 8'b0} + {r_era[8:0], 7'b0}
                    + {r_era[11:0], 4'b0} + 16'(mon_w <= 4'd2);

    always_comb begin
        div_ctl      = '0;
        div_dividend = '0;
        unique case (r_state)
            S_LOAD: begin
                div_ctl      = '{start: 1'b1, nbits: NB_SEC, divisor: ecal_pkg::DIV_MIN};
                div_dividend = r_t;
            end
            S_SEC: begin
                div_ctl      = '{start: div_stat.done, nbits: NB_MIN,
                                 divisor: ecal_pkg::DIV_MIN};
                div_dividend = {q[TW-6:0], 5'b0};
            end
            S_MIN: begin
                div_ctl      = '{start: div_stat.done, nbits: NB_HOUR,
                                 divisor: ecal_pkg::DIV_DAY};
                div_dividend = {q[TW-12:0], 11'b0};
            end
            S_HOUR: begin
                div_ctl      = '{start: div_stat.done, nbits: NB_ERA,
                                 divisor: ecal_pkg::DIV_ERA};
                div_dividend = {z, 16'b0};
            end
            S_ERA: begin
                div_ctl      = '{start: div_stat.done, nbits: NB_DOE,
                                 divisor: ecal_pkg::DIV_4Y};
                div_dividend = {div_stat.rem, {(TW-18){1'b0}}};
            end
            S_Q1: begin
                div_ctl      = '{start: div_stat.done, nbits: NB_DOE,
                                 divisor: ecal_pkg::DIV_100Y};
                div_dividend = {r_doe, {(TW-18){1'b0}}};
            end
            S_Q2: begin
                div_ctl      = '{start: div_stat.done, nbits: NB_DOE,
                                 divisor: ecal_pkg::DIV_400Y};
                div_dividend = {r_doe, {(TW-18){1'b0}}};
            end
            S_Q3: begin
                div_ctl      = '{start: div_stat.done, nbits: NB_DOE,
                                 divisor: ecal_pkg::DIV_YEAR};
                div_dividend = {acc_nx, {(TW-18){1'b0}}};
            end
            S_YOE: begin
                div_ctl      = '{start: div_stat.done, nbits: NB_YOE,
                                 divisor: ecal_pkg::DIV_CENTURY};
                div_dividend = {q[8:0], {(TW-9){1'b0}}};
            end
            S_C100: begin
                div_ctl      = '{start: div_stat.done, nbits: NB_DOY,
                                 divisor: ecal_pkg::DIV_MONTH};
                div_dividend = {{doy_w[8:0], 2'b00} + 11'(doy_w[8:0]) + 11'd2,
                                {(TW-11){1'b0}}};
            end
            S_MP: begin
                div_ctl      = '{start: div_stat.done, nbits: NB_DOY,
                                 divisor: ecal_pkg::DIV_FIVE};
                div_dividend = {11'(q[3:0]) * 11'd153 + 11'd2, {(TW-11){1'b0}}};
            end
            S_IDLE, S_DOM, S_OUT: begin
                div_ctl      = '0;
                div_dividend = '0;
            end
            default: begin
                div_ctl      = '0;
                div_dividend = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_zone      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_zone <= i_cfg_data;
            end
            // the output state refills the register itself
            if (r_out_valid && i_m_axis_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_t     <= t_sum;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_SEC;
                end
                S_SEC: begin
                    if (div_stat.done) begin
                        r_sec   <= div_stat.rem[5:0];
                        r_state <= S_MIN;
                    end
                end
                S_MIN: begin
                    if (div_stat.done) begin
                        r_min   <= div_stat.rem[5:0];
                        r_state <= S_HOUR;
                    end
                end
                S_HOUR: begin
                    if (div_stat.done) begin
                        r_hour  <= div_stat.rem[4:0];
                        r_state <= S_ERA;
                    end
                end
                S_ERA: begin
                    if (div_stat.done) begin
                        r_era   <= q[11:0];
                        r_doe   <= div_stat.rem;
                        r_state <= S_Q1;
                    end
                end
                S_Q1: begin
                    if (div_stat.done) begin
                        r_acc   <= r_doe - q[17:0];
                        r_state <= S_Q2;
                    end
                end
                S_Q2: begin
                    if (div_stat.done) begin
                        r_acc   <= r_acc + q[17:0];
                        r_state <= S_Q3;
                    end
                end
                S_Q3: begin
                    if (div_stat.done) begin
                        r_state <= S_YOE;
                    end
                end
                S_YOE: begin
                    if (div_stat.done) begin
                        r_yoe   <= q[8:0];
                        r_state <= S_C100;
                    end
                end
                S_C100: begin
                    if (div_stat.done) begin
                        r_doy   <= doy_w[8:0];
                        r_state <= S_MP;
                    end
                end
                S_MP: begin
                    if (div_stat.done) begin
                        r_mp    <= q[3:0];
                        r_state <= S_DOM;
                    end
                end
                S_DOM: begin
                    // quotient holds in the divider until the next start
                    if (div_stat.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_year    <= year_w;
                        r_o_mon     <= mon_w;
                        r_o_dom     <= dom_w[4:0];
                        r_o_hour    <= r_hour;
                        r_o_min     <= r_min;
                        r_o_sec     <= r_sec;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_o_sec, r_o_min, r_o_hour, r_o_dom, r_o_mon, r_o_year};

endmodule
